/* sv/gda_pkg.sv */
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, codes and calendar helpers for the Gregorian date unit.
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int YEAR_MAX   = 9999;
  localparam int YEAR_RESET = 2000;
  // Last month index (year * 12 + month - 1) of December 9999.
  localparam int TOT_MAX    = YEAR_MAX * 12 + 11;
  // floor(x / 3) = (x * DIV3_MUL) >> 17 for x < 2**16
  localparam int DIV3_MUL   = 43691;
  // floor(x / 25) = (x * DIV25_MUL) >> 16 for x < 2**12
  localparam int DIV25_MUL  = 2622;

  typedef enum logic [3:0] {
    REQ_SET_YEAR   = 4'd0,
    REQ_SET_MONTH  = 4'd1,
    REQ_SET_DAY    = 4'd2,
    REQ_ADD_DAYS   = 4'd3,
    REQ_SUB_DAYS   = 4'd4,
    REQ_ADD_MONTHS = 4'd5,
    REQ_SUB_MONTHS = 4'd6,
    REQ_ADD_YEARS  = 4'd7,
    REQ_SUB_YEARS  = 4'd8,
    REQ_COMPARE    = 4'd9
  } req_e;

  typedef enum logic [1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_EARLIER = 2'd1,
    ORD_LATER   = 2'd2
  } ord_e;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LATCH,
    CMD_SET_YEAR,
    CMD_SET_MONTH,
    CMD_SET_DAY,
    CMD_ADD_DAYS,
    CMD_SUB_DAYS,
    CMD_ADD_MONTHS,
    CMD_SUB_MONTHS,
    CMD_ADD_YEARS,
    CMD_SUB_YEARS,
    CMD_WALK_ADD,
    CMD_WALK_SUB,
    CMD_LEAP,
    CMD_FIX,
    CMD_MON_SAT,
    CMD_MON_MUL,
    CMD_MON_DIV,
    CMD_LOAD_OUT
  } dp_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK_ADD,
    ST_WALK_SUB,
    ST_WALK_LEAP,
    ST_MON_SAT,
    ST_MON_MUL,
    ST_MON_DIV,
    ST_LEAP,
    ST_FIX,
    ST_RESP
  } gda_state_e;

  typedef struct packed {
    logic set_year_ok;
    logic set_month_ok;
    logic add_stop;   // forward walk finishes this cycle
    logic add_wrap;   // forward walk crosses into a new year this cycle
    logic sub_stop;
    logic sub_wrap;
  } dp_status_t;

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:                  len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:               len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* sv/gda_ctrl.sv */
// ----------------------------------------------------------------------------
// gda_ctrl
// Request sequencer: decodes the request and steps the datapath through it.
// ----------------------------------------------------------------------------
module gda_ctrl import gda_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] req_type_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_e    cmd_o
);

  gda_state_e state_q, state_d;
  req_e       req_q;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= REQ_COMPARE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_IDLE && in_valid_i) begin
        req_q <= req_e'(req_type_i);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (req_q)
          REQ_SET_YEAR:   state_d = status_i.set_year_ok ? ST_LEAP : ST_RESP;
          REQ_SET_MONTH:  state_d = status_i.set_month_ok ? ST_FIX : ST_RESP;
          REQ_ADD_DAYS:   state_d = ST_WALK_ADD;
          REQ_SUB_DAYS:   state_d = ST_WALK_SUB;
          REQ_ADD_MONTHS,
          REQ_SUB_MONTHS: state_d = ST_MON_SAT;
          REQ_ADD_YEARS,
          REQ_SUB_YEARS:  state_d = ST_LEAP;
          default:        state_d = ST_RESP;
        endcase
      end
      ST_WALK_ADD: begin
        if (status_i.add_stop)      state_d = ST_RESP;
        else if (status_i.add_wrap) state_d = ST_WALK_LEAP;
      end
      ST_WALK_SUB: begin
        if (status_i.sub_stop)      state_d = ST_RESP;
        else if (status_i.sub_wrap) state_d = ST_WALK_LEAP;
      end
      ST_WALK_LEAP: state_d = (req_q == REQ_ADD_DAYS) ? ST_WALK_ADD : ST_WALK_SUB;
      ST_MON_SAT:   state_d = ST_MON_MUL;
      ST_MON_MUL:   state_d = ST_MON_DIV;
      ST_MON_DIV:   state_d = ST_LEAP;
      ST_LEAP:      state_d = ST_FIX;
      ST_FIX:       state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = CMD_NOP;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) cmd_o = CMD_LATCH;
      end
      ST_EXEC: begin
        unique case (req_q)
          REQ_SET_YEAR:   cmd_o = CMD_SET_YEAR;
          REQ_SET_MONTH:  cmd_o = CMD_SET_MONTH;
          REQ_SET_DAY:    cmd_o = CMD_SET_DAY;
          REQ_ADD_DAYS:   cmd_o = CMD_ADD_DAYS;
          REQ_SUB_DAYS:   cmd_o = CMD_SUB_DAYS;
          REQ_ADD_MONTHS: cmd_o = CMD_ADD_MONTHS;
          REQ_SUB_MONTHS: cmd_o = CMD_SUB_MONTHS;
          REQ_ADD_YEARS:  cmd_o = CMD_ADD_YEARS;
          REQ_SUB_YEARS:  cmd_o = CMD_SUB_YEARS;
          default:        cmd_o = CMD_NOP;
        endcase
      end
      ST_WALK_ADD:  cmd_o = CMD_WALK_ADD;
      ST_WALK_SUB:  cmd_o = CMD_WALK_SUB;
      ST_WALK_LEAP: cmd_o = CMD_LEAP;
      ST_MON_SAT:   cmd_o = CMD_MON_SAT;
      ST_MON_MUL:   cmd_o = CMD_MON_MUL;
      ST_MON_DIV:   cmd_o = CMD_MON_DIV;
      ST_LEAP:      cmd_o = CMD_LEAP;
      ST_FIX:       cmd_o = CMD_FIX;
      ST_RESP: begin
        if (out_free) begin
          cmd_o       = CMD_LOAD_OUT;
          out_valid_d = 1'b1;
        end
      end
      default:      cmd_o = CMD_NOP;
    endcase
  end

endmodule

/* sv/gda_dp.sv */
// ----------------------------------------------------------------------------
// gda_dp
// Date datapath: held date, day walk accumulator, month-index divider,
// leap-year unit and the result register.
// ----------------------------------------------------------------------------
module gda_dp import gda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_e     cmd_i,
  output dp_status_t  status_o,
  input  logic [14:0] operand_value_i,
  input  logic [13:0] cmp_year_i,
  input  logic [3:0]  cmp_month_i,
  input  logic [4:0]  cmp_day_i,
  output logic [13:0] cur_year_o,
  output logic [3:0]  cur_month_o,
  output logic [4:0]  cur_day_o,
  output logic [1:0]  order_code_o,
  output logic        range_flag_o
);

  // Held date
  logic [13:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic        leap_q;
  logic        sat_q;

  // Latched request and scratch
  logic [14:0]        val_q;
  logic [13:0]        cmp_year_q;
  logic [3:0]         cmp_month_q;
  logic [4:0]         cmp_day_q;
  logic signed [16:0] acc_q;
  logic signed [18:0] tot_q;
  logic [30:0]        prod_q;

  // Result register
  logic [13:0] cur_year_q;
  logic [3:0]  cur_month_q;
  logic [4:0]  cur_day_q;
  ord_e        order_q;
  logic        flag_q;

  logic [4:0]  lim, lim_prev;
  logic        acc_gt_lim, acc_le0, top_hit, bot_hit;
  logic        day_ok;
  logic signed [16:0] yr_step;
  logic [13:0] yr_sat;
  logic        yr_ovf;
  logic [16:0] mon_idx;
  logic signed [18:0] tot_step;
  logic [13:0] mq;
  logic [16:0] mq12, mrem;
  logic [23:0] lp_prod;
  logic [7:0]  cent;
  logic [13:0] cent100, yrem;
  logic        leap_calc;
  ord_e        order_calc;

  assign lim      = month_len(leap_q, month_q);
  assign lim_prev = month_len(leap_q, month_q - 4'd1);

  assign acc_gt_lim = !acc_q[16] && (acc_q[15:0] > {11'd0, lim});
  assign acc_le0    = acc_q[16] || (acc_q == 17'sd0);
  assign top_hit    = (month_q == 4'd12) && (year_q >= 14'(YEAR_MAX));
  assign bot_hit    = (month_q == 4'd1) && (year_q == 14'd0);
  assign day_ok     = (val_q != 15'd0) && (val_q <= {10'd0, lim});

  assign status_o.set_year_ok  = (val_q <= 15'(YEAR_MAX));
  assign status_o.set_month_ok = (val_q >= 15'd1) && (val_q <= 15'd12);
  assign status_o.add_stop     = !acc_gt_lim || top_hit;
  assign status_o.add_wrap     = acc_gt_lim && !top_hit && (month_q == 4'd12);
  assign status_o.sub_stop     = !acc_le0 || bot_hit;
  assign status_o.sub_wrap     = acc_le0 && !bot_hit && (month_q == 4'd1);

  // Year step with saturation
  assign yr_step = (cmd_i == CMD_SUB_YEARS) ?
                   $signed({3'b000, year_q}) - $signed({2'b00, val_q}) :
                   $signed({3'b000, year_q}) + $signed({2'b00, val_q});
  always_comb begin
    yr_ovf = 1'b0;
    yr_sat = yr_step[13:0];
    if (yr_step[16]) begin
      yr_ovf = 1'b1;
      yr_sat = 14'd0;
    end else if (yr_step > 17'(YEAR_MAX)) begin
      yr_ovf = 1'b1;
      yr_sat = 14'(YEAR_MAX);
    end
  end

  // Month index = year * 12 + month - 1, then the signed step
  assign mon_idx  = {year_q, 3'b000} + {1'b0, year_q, 2'b00} + {13'd0, month_q - 4'd1};
  assign tot_step = (cmd_i == CMD_SUB_MONTHS) ?
                    $signed({2'b00, mon_idx}) - $signed({4'd0, val_q}) :
                    $signed({2'b00, mon_idx}) + $signed({4'd0, val_q});

  // Month index / 12 from the registered product
  assign mq   = prod_q[30:17];
  assign mq12 = {mq, 3'b000} + {1'b0, mq, 2'b00};
  assign mrem = tot_q[16:0] - mq12;

  // Leap year: century = (year / 4) / 25
  assign lp_prod   = {12'd0, year_q[13:2]} * 24'(DIV25_MUL);
  assign cent      = lp_prod[23:16];
  assign cent100   = {cent, 6'b0} + {1'b0, cent, 5'b0} + {4'b0, cent, 2'b0};
  assign yrem      = year_q - cent100;
  assign leap_calc = ((year_q[1:0] == 2'b00) && (yrem != 14'd0)) ||
                     ((yrem == 14'd0) && (cent[1:0] == 2'b00));

  always_comb begin
    if (year_q != cmp_year_q) begin
      order_calc = (year_q < cmp_year_q) ? ORD_EARLIER : ORD_LATER;
    end else if (month_q != cmp_month_q) begin
      order_calc = (month_q < cmp_month_q) ? ORD_EARLIER : ORD_LATER;
    end else if (day_q != cmp_day_q) begin
      order_calc = (day_q < cmp_day_q) ? ORD_EARLIER : ORD_LATER;
    end else begin
      order_calc = ORD_EQUAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q  <= 14'(YEAR_RESET);
      month_q <= 4'd1;
      day_q   <= 5'd1;
      leap_q  <= 1'b1;
      sat_q   <= 1'b0;
    end else begin
      case (cmd_i)
        CMD_LATCH: sat_q <= 1'b0;
        CMD_SET_YEAR: begin
          if (status_o.set_year_ok) year_q <= val_q[13:0];
        end
        CMD_SET_MONTH: begin
          if (status_o.set_month_ok) month_q <= val_q[3:0];
        end
        CMD_SET_DAY: begin
          if (day_ok) day_q <= val_q[4:0];
        end
        CMD_ADD_YEARS, CMD_SUB_YEARS: begin
          year_q <= yr_sat;
          sat_q  <= yr_ovf;
        end
        CMD_WALK_ADD: begin
          if (!acc_gt_lim) begin
            day_q <= acc_q[4:0];
          end else if (top_hit) begin
            day_q <= 5'd31;
            sat_q <= 1'b1;
          end else if (month_q == 4'd12) begin
            month_q <= 4'd1;
            year_q  <= year_q + 14'd1;
          end else begin
            month_q <= month_q + 4'd1;
          end
        end
        CMD_WALK_SUB: begin
          if (!acc_le0) begin
            day_q <= acc_q[4:0];
          end else if (bot_hit) begin
            day_q <= 5'd1;
            sat_q <= 1'b1;
          end else if (month_q == 4'd1) begin
            month_q <= 4'd12;
            year_q  <= year_q - 14'd1;
          end else begin
            month_q <= month_q - 4'd1;
          end
        end
        CMD_LEAP: leap_q <= leap_calc;
        CMD_FIX: begin
          if (day_q > lim) day_q <= lim;
        end
        CMD_MON_SAT: sat_q <= tot_q[18] || (tot_q[17:0] > 18'(TOT_MAX));
        CMD_MON_DIV: begin
          year_q  <= mq;
          month_q <= mrem[3:0] + 4'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LATCH: begin
        val_q       <= operand_value_i;
        cmp_year_q  <= cmp_year_i;
        cmp_month_q <= cmp_month_i;
        cmp_day_q   <= cmp_day_i;
      end
      CMD_ADD_DAYS: acc_q <= $signed({12'd0, day_q}) + $signed({2'b00, val_q});
      CMD_SUB_DAYS: acc_q <= $signed({12'd0, day_q}) - $signed({2'b00, val_q});
      CMD_WALK_ADD: begin
        if (acc_gt_lim && !top_hit) acc_q <= acc_q - $signed({12'd0, lim});
      end
      CMD_WALK_SUB: begin
        // December is 31 days in every year, so the wrap needs no leap bit
        if (acc_le0 && !bot_hit) begin
          acc_q <= acc_q + $signed({12'd0, (month_q == 4'd1) ? 5'd31 : lim_prev});
        end
      end
      CMD_ADD_MONTHS, CMD_SUB_MONTHS: tot_q <= tot_step;
      CMD_MON_SAT: begin
        if (tot_q[18]) begin
          tot_q <= 19'sd0;
        end else if (tot_q[17:0] > 18'(TOT_MAX)) begin
          tot_q <= 19'(TOT_MAX);
        end
      end
      CMD_MON_MUL: prod_q <= {16'd0, tot_q[16:2]} * 31'(DIV3_MUL);
      CMD_LOAD_OUT: begin
        cur_year_q  <= year_q;
        cur_month_q <= month_q;
        cur_day_q   <= day_q;
        order_q     <= order_calc;
        flag_q      <= sat_q;
      end
      default: ;
    endcase
  end

  assign cur_year_o   = cur_year_q;
  assign cur_month_o  = cur_month_q;
  assign cur_day_o    = cur_day_q;
  assign order_code_o = order_q;
  assign range_flag_o = flag_q;

endmodule

/* sv/gregorian_date_arithmetic.sv */
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic
// Held Gregorian date (years 0..9999) with set, day/month/year step and
// compare requests.
// ----------------------------------------------------------------------------
// One request is processed at a time; a new item is taken while the previous
// result still waits in the output register. A day step walks the held date
// one month per cycle through the day accumulator, pausing for the leap-year
// unit at each year crossed. Years saturate at 0 and 9999 with range_flag
// set. Reset date is 2000-01-01.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic import gda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  req_type_i,
  input  logic [14:0] operand_value_i,
  input  logic [13:0] cmp_year_i,
  input  logic [3:0]  cmp_month_i,
  input  logic [4:0]  cmp_day_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [13:0] cur_year_o,
  output logic [3:0]  cur_month_o,
  output logic [4:0]  cur_day_o,
  output logic [1:0]  order_code_o,
  output logic        range_flag_o
);

  dp_cmd_e    cmd;
  dp_status_t status;

  gda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gda_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .operand_value_i (operand_value_i),
    .cmp_year_i      (cmp_year_i),
    .cmp_month_i     (cmp_month_i),
    .cmp_day_i       (cmp_day_i),
    .cur_year_o      (cur_year_o),
    .cur_month_o     (cur_month_o),
    .cur_day_o       (cur_day_o),
    .order_code_o    (order_code_o),
    .range_flag_o    (range_flag_o)
  );

endmodule
